/* rtl/fasta_index_builder_assert.svh */
// Assertion macros shared by the RTL. Each expands to one labeled
// concurrent assertion clocked on clk and disabled during rst.
`ifndef FASTA_INDEX_BUILDER_ASSERT_SVH
`define FASTA_INDEX_BUILDER_ASSERT_SVH

// Same-cycle implication
`define FIB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fib_pkg.sv */
package fib_pkg;

  localparam int POSITION_BITS   = 40;
  localparam int LINE_COUNT_BITS = 16;
  localparam int NAME_LEN_BITS   = 16;

  localparam logic [POSITION_BITS-1:0]   POS_MAX  = '1;
  localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;
  localparam logic [NAME_LEN_BITS-1:0]   NAME_MAX = '1;

  // Result queue geometry
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_GT = 8'h3E;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_HT = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    KIND_ENTRY    = 2'd0,
    KIND_BAD_NAME = 2'd1,
    KIND_END      = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    MODE_SEEK = 5'b00001,
    MODE_NAME = 5'b00010,
    MODE_DESC = 5'b00100,
    MODE_SEQ  = 5'b01000,
    MODE_HALT = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_t                      kind;
    logic [POSITION_BITS-1:0]   name_offset;
    logic [NAME_LEN_BITS-1:0]   name_length;
    logic [POSITION_BITS-1:0]   sequence_length;
    logic [POSITION_BITS-1:0]   sequence_offset;
    logic [LINE_COUNT_BITS-1:0] bases_per_line;
    logic [LINE_COUNT_BITS-1:0] bytes_per_line;
    logic                       last;
  } out_item_t;

endpackage

/* rtl/fasta_index_builder.sv */
// A byte's results are written into the result queue at its transaction and are shown
// on out_data once older results have drained. One byte per cycle while in_ready is high;
// a byte yields at most two results, queued in a four-entry result queue that drains one
// result per cycle while out_ready is high. in_ready drops while the queue holds more than two results.
// Reset (rst, synchronous): parser returns to "before first header", queue empties.
module fasta_index_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fib_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fib_pkg::out_item_t out_data
);
  import fib_pkg::*;

  // Parser state
  logic [POSITION_BITS-1:0]   byte_position, byte_position_next;
  mode_t                      mode, mode_next;
  logic                       at_line_start, at_line_start_next;
  logic                       have_sequence, have_sequence_next;
  logic [POSITION_BITS-1:0]   held_name_offset, held_name_offset_next;
  logic [NAME_LEN_BITS-1:0]   held_name_length, held_name_length_next;
  logic [POSITION_BITS-1:0]   held_base_total, held_base_total_next;
  logic [POSITION_BITS-1:0]   held_sequence_offset, held_sequence_offset_next;
  logic [LINE_COUNT_BITS-1:0] first_line_bases, first_line_bases_next;
  logic [LINE_COUNT_BITS-1:0] first_line_bytes, first_line_bytes_next;
  logic                       first_line_pending, first_line_pending_next;
  logic [LINE_COUNT_BITS-1:0] line_base_count, line_base_count_next;
  logic [LINE_COUNT_BITS-1:0] line_byte_count, line_byte_count_next;

  // Result queue
  out_item_t              queue [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]   count;

  logic                   in_fire, out_fire;
  logic [7:0]             b;
  logic                   eof, ws, is_lf, header, error;
  logic [POSITION_BITS-1:0] next_pos;
  logic                   entry_valid, tail_valid;
  out_item_t              entry, tail, res0, res1;
  logic [1:0]             push_cnt, push_n;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (count <= QCNT_BITS'(QDEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = queue[rd_ptr];

  assign b        = in_data.data_byte;
  assign eof      = in_data.end_of_file;
  assign ws       = (b == CHAR_SP) || (b >= CHAR_HT && b <= CHAR_CR);
  assign is_lf    = (b == CHAR_LF);
  assign next_pos = (byte_position == POS_MAX) ? byte_position
                                               : byte_position + POSITION_BITS'(1);
  assign header   = at_line_start && (b == CHAR_GT) &&
                    (mode == MODE_SEEK || mode == MODE_SEQ);

  // Next parser state and the results of the current byte
  always_comb begin
    byte_position_next        = byte_position;
    mode_next                 = mode;
    at_line_start_next        = at_line_start;
    have_sequence_next        = have_sequence;
    held_name_offset_next     = held_name_offset;
    held_name_length_next     = held_name_length;
    held_base_total_next      = held_base_total;
    held_sequence_offset_next = held_sequence_offset;
    first_line_bases_next     = first_line_bases;
    first_line_bytes_next     = first_line_bytes;
    first_line_pending_next   = first_line_pending;
    line_base_count_next      = line_base_count;
    line_byte_count_next      = line_byte_count;
    error       = 1'b0;
    entry_valid = 1'b0;
    tail_valid  = 1'b0;
    entry       = '0;
    tail        = '0;

    if (mode != MODE_HALT) begin
      // Entry of the previous sequence, closed by a new header
      entry.kind            = KIND_ENTRY;
      entry.name_offset     = held_name_offset;
      entry.name_length     = held_name_length;
      entry.sequence_length = held_base_total;
      entry.sequence_offset = held_sequence_offset;
      entry.bases_per_line  = first_line_bases;
      entry.bytes_per_line  = first_line_bytes;

      priority if (header) begin
        entry_valid               = have_sequence;
        held_name_offset_next     = next_pos;
        held_name_length_next     = '0;
        have_sequence_next        = 1'b0;
        held_base_total_next      = '0;
        held_sequence_offset_next = next_pos;
        first_line_bases_next     = '0;
        first_line_bytes_next     = '0;
        first_line_pending_next   = 1'b1;
        line_base_count_next      = '0;
        line_byte_count_next      = '0;
        mode_next                 = MODE_NAME;
        error                     = eof;
      end else if (mode == MODE_NAME) begin
        held_sequence_offset_next = next_pos;
        if (ws) begin
          if (!have_sequence) begin
            error = 1'b1;
          end else begin
            mode_next = is_lf ? MODE_SEQ : MODE_DESC;
          end
        end else begin
          if (held_name_length != NAME_MAX) begin
            held_name_length_next = held_name_length + NAME_LEN_BITS'(1);
          end
          have_sequence_next = 1'b1;
        end
      end else if (mode == MODE_DESC) begin
        held_sequence_offset_next = next_pos;
        if (is_lf) begin
          mode_next = MODE_SEQ;
        end
      end else if (mode == MODE_SEQ) begin
        if (line_byte_count != LINE_MAX) begin
          line_byte_count_next = line_byte_count + LINE_COUNT_BITS'(1);
        end
        if (!ws) begin
          if (line_base_count != LINE_MAX) begin
            line_base_count_next = line_base_count + LINE_COUNT_BITS'(1);
          end
          if (held_base_total != POS_MAX) begin
            held_base_total_next = held_base_total + POSITION_BITS'(1);
          end
        end
        if (is_lf) begin
          if (first_line_pending) begin
            first_line_bases_next   = line_base_count_next;
            first_line_bytes_next   = line_byte_count_next;
            first_line_pending_next = 1'b0;
          end
          line_base_count_next = '0;
          line_byte_count_next = '0;
        end
      end else begin
        // before first header: only position tracking
      end

      if (error) begin
        // Empty name: report and halt
        tail_valid       = 1'b1;
        tail.kind        = KIND_BAD_NAME;
        tail.name_offset = held_name_offset_next;
        mode_next        = MODE_HALT;
      end else begin
        at_line_start_next = is_lf;
        byte_position_next = next_pos;
        if (eof) begin
          // Unterminated last line may still be the first line
          if (mode_next == MODE_SEQ && line_byte_count_next != '0 &&
              first_line_pending_next) begin
            first_line_bases_next   = line_base_count_next;
            first_line_bytes_next   = line_byte_count_next;
            first_line_pending_next = 1'b0;
          end
          entry_valid           = have_sequence_next;
          entry.name_offset     = held_name_offset_next;
          entry.name_length     = held_name_length_next;
          entry.sequence_length = held_base_total_next;
          entry.sequence_offset = held_sequence_offset_next;
          entry.bases_per_line  = first_line_bases_next;
          entry.bytes_per_line  = first_line_bytes_next;
          tail_valid            = 1'b1;
          tail.kind             = KIND_END;
          // Back to the reset state for the next file
          byte_position_next        = '0;
          mode_next                 = MODE_SEEK;
          at_line_start_next        = 1'b1;
          have_sequence_next        = 1'b0;
          held_name_offset_next     = '0;
          held_name_length_next     = '0;
          held_base_total_next      = '0;
          held_sequence_offset_next = '0;
          first_line_bases_next     = '0;
          first_line_bytes_next     = '0;
          first_line_pending_next   = 1'b1;
          line_base_count_next      = '0;
          line_byte_count_next      = '0;
        end
      end
    end
  end

  // Order results: entry first, then error or end marker
  always_comb begin
    res0 = entry_valid ? entry : tail;
    res0.last = !(entry_valid && tail_valid);
    res1 = tail;
    res1.last = 1'b1;
    push_cnt = {1'b0, entry_valid} + {1'b0, tail_valid};
    push_n   = in_fire ? push_cnt : 2'd0;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      mode                 <= MODE_SEEK;
      at_line_start        <= 1'b1;
      have_sequence        <= 1'b0;
      held_name_offset     <= '0;
      held_name_length     <= '0;
      held_base_total      <= '0;
      held_sequence_offset <= '0;
      first_line_bases     <= '0;
      first_line_bytes     <= '0;
      first_line_pending   <= 1'b1;
      line_base_count      <= '0;
      line_byte_count      <= '0;
    end else if (in_fire) begin
      byte_position        <= byte_position_next;
      mode                 <= mode_next;
      at_line_start        <= at_line_start_next;
      have_sequence        <= have_sequence_next;
      held_name_offset     <= held_name_offset_next;
      held_name_length     <= held_name_length_next;
      held_base_total      <= held_base_total_next;
      held_sequence_offset <= held_sequence_offset_next;
      first_line_bases     <= first_line_bases_next;
      first_line_bytes     <= first_line_bytes_next;
      first_line_pending   <= first_line_pending_next;
      line_base_count      <= line_base_count_next;
      line_byte_count      <= line_byte_count_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QPTR_BITS'(1)] <= res1;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count + QCNT_BITS'(push_n) - QCNT_BITS'(out_fire);
    end
  end

  `include "fasta_index_builder_assert.svh"

  `FIB_ASSERT_NOW(a_queue_bound, 1'b1, count <= QCNT_BITS'(QDEPTH), "result queue overflow")
  `FIB_ASSERT_NOW(a_halt_silent, in_fire && mode == MODE_HALT, push_n == 2'd0, "result after halt")
  `FIB_ASSERT_NEXT(a_error_halts, in_fire && error, mode == MODE_HALT, "empty name did not halt")
  `FIB_ASSERT_NEXT(a_eof_resets, in_fire && eof && !error && mode != MODE_HALT, mode == MODE_SEEK && byte_position == '0, "end of file did not reset parser")

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fib_pkg::*;

  localparam int GAP_MAX      = 6;
  localparam int BURST_MAX    = 24;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 20;
  // Worst case: a few hundred bytes, each with the longest gap and two results
  // that each wait out the longest stall, taken many times over.
  localparam longint unsigned CYCLE_LIMIT = 64'd500_000;

  localparam logic [7:0] CH_N = "N";

  // Parser state mirrored by the predictor
  typedef struct {
    logic [POSITION_BITS-1:0]   pos;
    mode_t                      mode;
    bit                         at_line_start;
    bit                         have_seq;
    logic [POSITION_BITS-1:0]   name_off;
    logic [NAME_LEN_BITS-1:0]   name_count;
    logic [POSITION_BITS-1:0]   base_total;
    logic [POSITION_BITS-1:0]   seq_off;
    logic [LINE_COUNT_BITS-1:0] first_bases;
    logic [LINE_COUNT_BITS-1:0] first_bytes;
    bit                         first_pending;
    logic [LINE_COUNT_BITS-1:0] cur_bases;
    logic [LINE_COUNT_BITS-1:0] cur_bytes;
  } parser_t;

  // Directed stimulus row; typed rows carry a single end-of-file result
  typedef struct packed {
    logic [7:0] data_byte;
    logic       eof;
    logic       typed;
    kind_t      kind;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00,   1'b0, 1'b0, KIND_ENTRY},  // junk before any header
    '{8'hFF,   1'b0, 1'b0, KIND_ENTRY},
    '{CHAR_GT, 1'b0, 1'b0, KIND_ENTRY},  // '>' mid-line, ignored
    '{CHAR_LF, 1'b0, 1'b0, KIND_ENTRY},
    '{CHAR_GT, 1'b0, 1'b0, KIND_ENTRY},  // first header
    '{"A",     1'b0, 1'b0, KIND_ENTRY},
    '{8'h80,   1'b0, 1'b0, KIND_ENTRY},  // high byte is a name char
    '{CHAR_HT, 1'b0, 1'b0, KIND_ENTRY},  // tab starts description
    '{"x",     1'b0, 1'b0, KIND_ENTRY},
    '{CHAR_LF, 1'b0, 1'b0, KIND_ENTRY},
    '{"A",     1'b0, 1'b0, KIND_ENTRY},
    '{CHAR_SP, 1'b0, 1'b0, KIND_ENTRY},  // space counts as byte, not base
    '{8'h00,   1'b0, 1'b0, KIND_ENTRY},  // NUL counts as base
    '{CHAR_LF, 1'b0, 1'b0, KIND_ENTRY},
    '{CHAR_LF, 1'b0, 1'b0, KIND_ENTRY},  // empty line
    '{CHAR_GT, 1'b0, 1'b0, KIND_ENTRY},  // closes first record
    '{"B",     1'b0, 1'b0, KIND_ENTRY},
    '{CHAR_LF, 1'b0, 1'b0, KIND_ENTRY},
    '{"G",     1'b1, 1'b0, KIND_ENTRY},  // last line with no newline
    '{"q",     1'b1, 1'b1, KIND_END},    // eof with no record open
    '{CHAR_GT, 1'b0, 1'b0, KIND_ENTRY},
    '{"Z",     1'b1, 1'b0, KIND_ENTRY},  // eof inside name
    '{CHAR_LF, 1'b1, 1'b1, KIND_END},    // eof on whitespace, nothing open
    '{CHAR_GT, 1'b0, 1'b0, KIND_ENTRY},
    '{"C",     1'b0, 1'b0, KIND_ENTRY},
    '{CHAR_LF, 1'b1, 1'b0, KIND_ENTRY}   // eof right after header line
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  parser_t          parser;
  out_item_t        index_q[$];
  out_item_t        want;
  int               err_count;
  int               parsed_bytes;
  int               burst_left;
  bit               no_idle;
  longint unsigned  cycle_count = 0;
  logic [15:0]      rdy_pat = '1;

  fasta_index_builder i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating counters and byte classes
  function automatic bit is_ws(logic [7:0] b);
    return (b == CHAR_SP) || (b >= CHAR_HT && b <= CHAR_CR);
  endfunction

  function automatic logic [POSITION_BITS-1:0] pos_inc(logic [POSITION_BITS-1:0] x);
    return (x == POS_MAX) ? x : x + 1'b1;
  endfunction

  function automatic logic [LINE_COUNT_BITS-1:0] line_inc(logic [LINE_COUNT_BITS-1:0] x);
    return (x == LINE_MAX) ? x : x + 1'b1;
  endfunction

  function automatic logic [NAME_LEN_BITS-1:0] name_inc(logic [NAME_LEN_BITS-1:0] x);
    return (x == NAME_MAX) ? x : x + 1'b1;
  endfunction

  function automatic parser_t parser_reset();
    parser_t s;
    s.pos           = '0;
    s.mode          = MODE_SEEK;
    s.at_line_start = 1'b1;
    s.have_seq      = 1'b0;
    s.name_off      = '0;
    s.name_count    = '0;
    s.base_total    = '0;
    s.seq_off       = '0;
    s.first_bases   = '0;
    s.first_bytes   = '0;
    s.first_pending = 1'b1;
    s.cur_bases     = '0;
    s.cur_bytes     = '0;
    return s;
  endfunction

  function automatic out_item_t entry_of(parser_t s);
    out_item_t r;
    r.kind            = KIND_ENTRY;
    r.name_offset     = s.name_off;
    r.name_length     = s.name_count;
    r.sequence_length = s.base_total;
    r.sequence_offset = s.seq_off;
    r.bases_per_line  = s.first_bases;
    r.bytes_per_line  = s.first_bytes;
    r.last            = 1'b0;
    return r;
  endfunction

  // Advance the parser by one byte, appending the index results it causes
  function automatic void index_step(inout parser_t s, input logic [7:0] b,
                                     input bit eof, inout out_item_t res[$]);
    bit                       ws;
    bit                       bad;
    logic [POSITION_BITS-1:0] npos;
    int                       first;
    out_item_t                r;
    ws    = is_ws(b);
    npos  = pos_inc(s.pos);
    bad   = 1'b0;
    first = res.size();
    if (s.mode == MODE_HALT) return;

    if (s.at_line_start && b == CHAR_GT && (s.mode == MODE_SEEK || s.mode == MODE_SEQ)) begin
      if (s.have_seq) res.push_back(entry_of(s));
      s.name_off      = npos;
      s.name_count    = '0;
      s.have_seq      = 1'b0;
      s.base_total    = '0;
      s.seq_off       = npos;
      s.first_bases   = '0;
      s.first_bytes   = '0;
      s.first_pending = 1'b1;
      s.cur_bases     = '0;
      s.cur_bytes     = '0;
      s.mode          = MODE_NAME;
      if (eof) bad = 1'b1;
    end else if (s.mode == MODE_NAME) begin
      s.seq_off = npos;
      if (ws) begin
        if (!s.have_seq) bad = 1'b1;
        else s.mode = (b == CHAR_LF) ? MODE_SEQ : MODE_DESC;
      end else begin
        s.name_count = name_inc(s.name_count);
        s.have_seq   = 1'b1;
      end
    end else if (s.mode == MODE_DESC) begin
      s.seq_off = npos;
      if (b == CHAR_LF) s.mode = MODE_SEQ;
    end else if (s.mode == MODE_SEQ) begin
      s.cur_bytes = line_inc(s.cur_bytes);
      if (!ws) begin
        s.cur_bases  = line_inc(s.cur_bases);
        s.base_total = pos_inc(s.base_total);
      end
      if (b == CHAR_LF) begin
        if (s.first_pending) begin
          s.first_bases   = s.cur_bases;
          s.first_bytes   = s.cur_bytes;
          s.first_pending = 1'b0;
        end
        s.cur_bases = '0;
        s.cur_bytes = '0;
      end
    end

    // Empty name: report and halt for good
    if (bad) begin
      r             = '0;
      r.kind        = KIND_BAD_NAME;
      r.name_offset = s.name_off;
      r.last        = 1'b1;
      res.push_back(r);
      s.mode = MODE_HALT;
      return;
    end

    s.at_line_start = (b == CHAR_LF);
    s.pos           = npos;

    // End of file: flush open record, then end marker
    if (eof) begin
      if (s.mode == MODE_SEQ && s.cur_bytes != 0 && s.first_pending) begin
        s.first_bases   = s.cur_bases;
        s.first_bytes   = s.cur_bytes;
        s.first_pending = 1'b0;
      end
      if (s.have_seq) res.push_back(entry_of(s));
      r      = '0;
      r.kind = KIND_END;
      res.push_back(r);
      s = parser_reset();
    end

    if (res.size() > first) begin
      r      = res[res.size()-1];
      r.last = 1'b1;
      res[res.size()-1] = r;
    end
  endfunction

  // Random byte helpers
  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return CHAR_SP;
    endcase
  endfunction

  function automatic logic [7:0] rand_nonws();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (is_ws(b)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] seq_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) != 0) begin
      case ($urandom_range(0, 3))
        0:       return "A";
        1:       return "C";
        2:       return "G";
        default: return "T";
      endcase
    end
    b = 8'($urandom_range(0, 255));
    while (b == CHAR_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Offer one byte, wait for its transaction, then predict its results
  task automatic send_byte(input logic [7:0] b, input bit eof, input bit typed,
                           input out_item_t typed_res);
    out_item_t res[$];
    if (!no_idle && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
      burst_left = $urandom_range(1, BURST_MAX);
    end
    in_valid <= 1'b1;
    in_data  <= {b, eof};
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    index_step(parser, b, eof, res);
    if (parser.mode != MODE_SEEK || res.size() != 0) parsed_bytes++;
    if (typed) index_q.push_back(typed_res);
    else foreach (res[i]) index_q.push_back(res[i]);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic put_byte(input logic [7:0] b, input bit eof);
    send_byte(b, eof, 1'b0, '0);
  endtask

  // Swap out any byte that would halt the parser before the final phase
  task automatic safe_byte(input logic [7:0] b, input bit eof);
    parser_t   t;
    out_item_t tr[$];
    t = parser;
    index_step(t, b, eof, tr);
    foreach (tr[i]) if (tr[i].kind == KIND_BAD_NAME) b = CH_N;
    put_byte(b, eof);
  endtask

  // One random file: mostly well-formed records, some noise, some without eof
  task automatic gen_file();
    logic [7:0] fb[$];
    logic [7:0] sep;
    int         nrec;
    bit         with_eof;
    no_idle  = ($urandom_range(0, 4) == 0);
    with_eof = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(5, 30)) begin
        case ($urandom_range(0, 3))
          0:       fb.push_back(CHAR_GT);
          1:       fb.push_back(CHAR_LF);
          default: fb.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      nrec = $urandom_range(1, 4);
      for (int r = 0; r < nrec; r++) begin
        fb.push_back(CHAR_GT);
        repeat ($urandom_range(1, 8)) fb.push_back(rand_nonws());
        if ($urandom_range(0, 2) == 0) begin
          sep = rand_ws();
          while (sep == CHAR_LF) sep = rand_ws();
          fb.push_back(sep);
          repeat ($urandom_range(0, 6)) begin
            sep = 8'($urandom_range(0, 255));
            fb.push_back((sep == CHAR_LF) ? CH_N : sep);
          end
        end
        fb.push_back(CHAR_LF);
        repeat ($urandom_range(0, 4)) begin
          repeat ($urandom_range(0, 12)) fb.push_back(seq_byte());
          fb.push_back(CHAR_LF);
        end
        // unterminated tail, normally only on the last record
        if ((r == nrec - 1 || $urandom_range(0, 9) == 0) && $urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 12)) fb.push_back(seq_byte());
      end
    end
    foreach (fb[i]) safe_byte(fb[i], with_eof && (i == fb.size() - 1));
  endtask

  // Receiver stall pattern, reloaded whenever the low byte of cycle_count is zero; cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'd0) begin
      if ($urandom_range(0, 3) == 0) rdy_pat <= '1;
      else rdy_pat <= 16'($urandom) | 16'h0001;
    end else begin
      rdy_pat <= {rdy_pat[14:0], rdy_pat[15]};
    end
    out_ready <= rdy_pat[0];
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Compare each result transaction with the oldest expected index result
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (index_q.size() == 0) begin
        $error("unexpected result transaction, kind %0d", out_data.kind);
        err_count++;
      end else begin
        want = index_q.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          err_count++;
        end
        if (out_data.name_offset !== want.name_offset) begin
          $error("name_offset: expected %0d, got %0d", want.name_offset, out_data.name_offset);
          err_count++;
        end
        if (out_data.name_length !== want.name_length) begin
          $error("name_length: expected %0d, got %0d", want.name_length, out_data.name_length);
          err_count++;
        end
        if (out_data.sequence_length !== want.sequence_length) begin
          $error("sequence_length: expected %0d, got %0d",
                 want.sequence_length, out_data.sequence_length);
          err_count++;
        end
        if (out_data.sequence_offset !== want.sequence_offset) begin
          $error("sequence_offset: expected %0d, got %0d",
                 want.sequence_offset, out_data.sequence_offset);
          err_count++;
        end
        if (out_data.bases_per_line !== want.bases_per_line) begin
          $error("bases_per_line: expected %0d, got %0d",
                 want.bases_per_line, out_data.bases_per_line);
          err_count++;
        end
        if (out_data.bytes_per_line !== want.bytes_per_line) begin
          $error("bytes_per_line: expected %0d, got %0d",
                 want.bytes_per_line, out_data.bytes_per_line);
          err_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          err_count++;
        end
      end
    end
  end

  initial begin
    out_item_t typed_res;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    parser       = parser_reset();
    err_count    = 0;
    parsed_bytes = 0;
    burst_left   = 0;
    no_idle      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_res      = '0;
      typed_res.kind = DIRECTED[i].kind;
      typed_res.last = 1'b1;
      send_byte(DIRECTED[i].data_byte, DIRECTED[i].eof, DIRECTED[i].typed, typed_res);
    end

    // Random files
    parsed_bytes = 0;
    while (parsed_bytes < RANDOM_ITEMS) gen_file();
    safe_byte(CHAR_LF, 1'b1);

    // Empty name last, since it halts the block; later bytes give nothing
    if ($urandom_range(0, 1) == 0) begin
      put_byte(CHAR_GT, 1'b1);
    end else begin
      put_byte(CHAR_GT, 1'b0);
      put_byte(rand_ws(), 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(2, 5)) put_byte(8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1)));
    put_byte(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    while (index_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && index_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fib_pkg.sv
rtl/fasta_index_builder.sv
tb/tb_top.sv
